### src/assert_macros.svh
// Concurrent assertion helpers, sampled on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds on the same edge.
`define ASSERT_AT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent that holds on the clock edge after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/kbdscan_pkg.sv
package kbdscan_pkg;

	localparam int unsigned FIFO_SLOTS_DEFAULT = 128;

	// action codes
	localparam logic [1:0] ACT_CODE = 2'd0;
	localparam logic [1:0] ACT_READ = 2'd1;
	localparam logic [1:0] ACT_POLL = 2'd2;

	// status codes
	localparam logic [2:0] ST_POLL    = 3'd0;
	localparam logic [2:0] ST_STORED  = 3'd1;
	localparam logic [2:0] ST_RELEASE = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_READ    = 3'd4;
	localparam logic [2:0] ST_EMPTY   = 3'd5;

	// top bit of a set 1 code marks a key release
	localparam int unsigned RELEASE_BIT = 7;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] scan_code;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [6:0] character;
		logic       has_data;
	} rsp_t;

	// word between the FIFO stage and the translate stage
	typedef struct packed {
		logic       valid;
		logic [2:0] status;
		logic       has_data;
		logic [6:0] code;
	} stage_t;

	// set 1 make code to ASCII; codes without an entry give 0
	function automatic logic [6:0] set1_ascii(input logic [6:0] code);
		logic [6:0] ch;
		unique case (code)
			7'd1:    ch = 7'h1b;
			7'd2:    ch = 7'h31;
			7'd3:    ch = 7'h32;
			7'd4:    ch = 7'h33;
			7'd5:    ch = 7'h34;
			7'd6:    ch = 7'h35;
			7'd7:    ch = 7'h36;
			7'd8:    ch = 7'h37;
			7'd9:    ch = 7'h38;
			7'd10:   ch = 7'h39;
			7'd11:   ch = 7'h30;
			7'd12:   ch = 7'h2d;
			7'd13:   ch = 7'h3d;
			7'd14:   ch = 7'h08;
			7'd15:   ch = 7'h09;
			7'd16:   ch = 7'h71;
			7'd17:   ch = 7'h77;
			7'd18:   ch = 7'h65;
			7'd19:   ch = 7'h72;
			7'd20:   ch = 7'h74;
			7'd21:   ch = 7'h79;
			7'd22:   ch = 7'h75;
			7'd23:   ch = 7'h69;
			7'd24:   ch = 7'h6f;
			7'd25:   ch = 7'h70;
			7'd26:   ch = 7'h5b;
			7'd27:   ch = 7'h5d;
			7'd28:   ch = 7'h0a;
			7'd30:   ch = 7'h61;
			7'd31:   ch = 7'h73;
			7'd32:   ch = 7'h64;
			7'd33:   ch = 7'h66;
			7'd34:   ch = 7'h67;
			7'd35:   ch = 7'h68;
			7'd36:   ch = 7'h6a;
			7'd37:   ch = 7'h6b;
			7'd38:   ch = 7'h6c;
			7'd39:   ch = 7'h3b;
			7'd40:   ch = 7'h27;
			7'd41:   ch = 7'h60;
			7'd43:   ch = 7'h5c;
			7'd44:   ch = 7'h7a;
			7'd45:   ch = 7'h78;
			7'd46:   ch = 7'h63;
			7'd47:   ch = 7'h76;
			7'd48:   ch = 7'h62;
			7'd49:   ch = 7'h6e;
			7'd50:   ch = 7'h6d;
			7'd51:   ch = 7'h2c;
			7'd52:   ch = 7'h2e;
			7'd53:   ch = 7'h2f;
			7'd55:   ch = 7'h2a;
			7'd57:   ch = 7'h20;
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

endpackage

### src/kbdscan_fifo.sv
`include "assert_macros.svh"

module kbdscan_fifo #(
	parameter int unsigned FIFO_SLOTS = kbdscan_pkg::FIFO_SLOTS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  kbdscan_pkg::req_t    request,
	output kbdscan_pkg::stage_t  stage
);

	localparam int unsigned PTR_W = $clog2(FIFO_SLOTS);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_SLOTS - 1);

	logic [6:0]       mem [FIFO_SLOTS];
	logic [PTR_W-1:0] rp_q, wp_q;
	logic [PTR_W-1:0] rp_adv, wp_adv, rp_d, wp_d;
	logic             empty, full, push, pop;
	logic [2:0]       status_d;
	logic             valid_s1, has_data_s1;
	logic [2:0]       status_s1;
	logic [6:0]       code_s1;

	assign rp_adv = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
	assign wp_adv = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
	assign empty  = (rp_q == wp_q);
	assign full   = (wp_adv == rp_q);

	always_comb begin
		push     = 1'b0;
		pop      = 1'b0;
		status_d = kbdscan_pkg::ST_POLL;
		unique case (request.action)
			kbdscan_pkg::ACT_CODE: begin
				if (request.scan_code[kbdscan_pkg::RELEASE_BIT]) begin
					status_d = kbdscan_pkg::ST_RELEASE;
				end else if (full) begin
					status_d = kbdscan_pkg::ST_FULL;
				end else begin
					push     = take;
					status_d = kbdscan_pkg::ST_STORED;
				end
			end
			kbdscan_pkg::ACT_READ: begin
				if (empty) begin
					status_d = kbdscan_pkg::ST_EMPTY;
				end else begin
					pop      = take;
					status_d = kbdscan_pkg::ST_READ;
				end
			end
			default: status_d = kbdscan_pkg::ST_POLL;
		endcase
	end

	assign rp_d = pop  ? rp_adv : rp_q;
	assign wp_d = push ? wp_adv : wp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q     <= '0;
			wp_q     <= '0;
			valid_s1 <= 1'b0;
		end else begin
			rp_q     <= rp_d;
			wp_q     <= wp_d;
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		status_s1   <= status_d;
		has_data_s1 <= (rp_d != wp_d);
	end

	// a pop never meets the slot written in the same cycle, so no bypass
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= request.scan_code[6:0];
		end
		code_s1 <= mem[rp_q];
	end

	assign stage = '{valid: valid_s1, status: status_s1, has_data: has_data_s1,
		code: code_s1};

	`ASSERT_AT_CLK(a_ptr_range, ({1'b0, rp_q} < (PTR_W+1)'(FIFO_SLOTS)) &&
		({1'b0, wp_q} < (PTR_W+1)'(FIFO_SLOTS)), "FIFO pointer beyond last slot")
	`ASSERT_NEXT(a_pop_moves, pop, rp_q != $past(rp_q), "pop did not advance read pointer")
	`ASSERT_NEXT(a_push_moves, push, (wp_q != $past(wp_q)) && (wp_q != rp_q),
		"push did not advance write pointer or overran")

endmodule

### src/kbdscan_xlat.sv
`include "assert_macros.svh"

module kbdscan_xlat (
	input  logic                clk,
	input  logic                arst_n,
	input  kbdscan_pkg::stage_t stage,
	output logic                done,
	output kbdscan_pkg::rsp_t   response
);

	logic              done_s2;
	kbdscan_pkg::rsp_t rsp_s2;
	logic [6:0]        ch_d;

	// translate only on a successful pop
	assign ch_d = (stage.status == kbdscan_pkg::ST_READ) ?
		kbdscan_pkg::set1_ascii(stage.code) : 7'h00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= stage.valid;
		end
	end

	always_ff @(posedge clk) begin
		rsp_s2 <= '{status: stage.status, character: ch_d, has_data: stage.has_data};
	end

	assign done     = done_s2;
	assign response = rsp_s2;

	`ASSERT_NEXT(a_done_follows, stage.valid, done_s2, "result word lost")
	`ASSERT_NEXT(a_no_spurious, !stage.valid, !done_s2, "result word without an item")
	`ASSERT_AT_CLK(a_char_only_read, !done_s2 || (rsp_s2.status == kbdscan_pkg::ST_READ) ||
		(rsp_s2.character == 7'h00), "character on a non-read result")

endmodule

### src/keyboard_scancode_fifo_translate_core.sv
// Channel   Handshake            Word
// command   start / busy         request  (action, scan_code)
// result    done (strobe only)   response (status, character, has_data)
//
// One command is taken per cycle while busy is low; its result passes the stage
// register (s1) and the result register (s2) before it is on response, held for
// the single cycle that done is high. The read port of the code store is registered.
// busy is high during reset and the first edge after it, then stays low.
// Reset empties the FIFO by clearing both pointers; the store itself is not cleared.
module keyboard_scancode_fifo_translate_core #(
	parameter int unsigned FIFO_SLOTS = kbdscan_pkg::FIFO_SLOTS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  kbdscan_pkg::req_t request,
	output logic              done,
	output kbdscan_pkg::rsp_t response
);

	logic                busy_q;
	logic                take;
	kbdscan_pkg::stage_t stage;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign take = start && !busy_q;

	kbdscan_fifo #(
		.FIFO_SLOTS(FIFO_SLOTS)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.request(request),
		.stage  (stage)
	);

	kbdscan_xlat u_xlat (
		.clk     (clk),
		.arst_n  (arst_n),
		.stage   (stage),
		.done    (done),
		.response(response)
	);

endmodule
